>>> hdl/dlf_pkg.sv
// dlf_pkg: shared types, constants and the sigmoid table for the dense layer block
// no dependencies; used by dlf_lane, dlf_merge and dense_layer_forward

package dlf_pkg;

  localparam int LANES          = 4;
  localparam int DATA_W         = 16;
  localparam int PROD_W         = 32;
  localparam int SUM_W          = 40;
  localparam int SIG_DEPTH      = 256;
  localparam int SIG_IDX_W      = $clog2(SIG_DEPTH);
  localparam int SIG_SPAN_W     = 28;
  localparam int RES_FIFO_DEPTH = 8;
  localparam int RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
  localparam int RES_CNT_W      = RES_PTR_W + 1;

  localparam logic [DATA_W-1:0] RELU_MAX = 16'h7fff;

  localparam logic MODE_RELU    = 1'b0;
  localparam logic MODE_SIGMOID = 1'b1;

  // input word: one activation and one weight (or bias) per lane
  typedef struct packed {
    logic signed [DATA_W-1:0] activation_in;
    logic signed [DATA_W-1:0] weight_lane0;
    logic signed [DATA_W-1:0] weight_lane1;
    logic signed [DATA_W-1:0] weight_lane2;
    logic signed [DATA_W-1:0] weight_lane3;
    logic                     bias_item;
  } in_word_t;

  // result word: activated lane outputs and the saturation flag
  typedef struct packed {
    logic signed [DATA_W-1:0] neuron_out0;
    logic signed [DATA_W-1:0] neuron_out1;
    logic signed [DATA_W-1:0] neuron_out2;
    logic signed [DATA_W-1:0] neuron_out3;
    logic                     saturated;
  } out_word_t;

  // per-stage control broadcast to every lane
  typedef struct packed {
    logic take;       // word accepted this cycle
    logic take_bias;  // accepted word is a bias row
    logic a_vld;      // product stage holds a word
    logic a_bias;     // product stage word is a bias row
    logic b_vld;      // final sums are ready for activation
    logic b_sig;      // use sigmoid for these final sums
  } lane_ctl_t;

  typedef logic [SIG_DEPTH-1:0][DATA_W-1:0] sig_rom_t;

  // unsigned shift-subtract quotient, used only while building the table
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    int              b;
    q = '0;
    r = '0;
    for (b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-f in Q30 for 0 <= f <= 1.0 (Q30), alternating power series
  function automatic longint unsigned exp_neg_frac(input longint unsigned f);
    longint unsigned acc;
    longint unsigned term;
    longint unsigned k;
    acc  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (k = 1; k < 24; k++) begin
      term = udiv64((term * f) >> 30, k);
      if (k[0]) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

  // sigmoid at each bin center over -8..8, rounded to Q4.12
  function automatic sig_rom_t build_sig_table();
    sig_rom_t        t;
    longint          i;
    longint          n;
    longint          c;
    longint          a;
    longint          whole;
    longint unsigned frac;
    longint unsigned e;
    longint unsigned e1;
    longint unsigned num;
    longint unsigned s;
    e1 = exp_neg_frac(64'd1 << 30);
    for (i = 0; i < SIG_DEPTH; i++) begin
      c     = ((2 * i + 1) * (64'sd1 <<< 27)) / SIG_DEPTH - (64'sd1 <<< 27);
      a     = (c < 0) ? -c : c;
      whole = a >>> 24;
      frac  = 64'((a & ((64'sd1 <<< 24) - 1)) <<< 6);
      e     = exp_neg_frac(frac);
      for (n = 0; n < whole; n++) begin
        e = (e * e1) >> 30;
      end
      num  = (c < 0) ? e : (64'd1 << 30);
      s    = udiv64(num << 30, (64'd1 << 30) + e);
      t[i] = DATA_W'((s * 64'd4096 + (64'd1 << 29)) >> 30);
    end
    return t;
  endfunction

  localparam sig_rom_t SIG_TABLE = build_sig_table();

endpackage

>>> hdl/dlf_lane.sv
// dlf_lane: one neuron lane - multiply, accumulate, then ReLU or sigmoid
// depends on dlf_pkg (types, widths, sigmoid table)

module dlf_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dlf_pkg::lane_ctl_t                ctl,
  input  logic signed [dlf_pkg::DATA_W-1:0] act_in,
  input  logic signed [dlf_pkg::DATA_W-1:0] weight_in,
  output logic        [dlf_pkg::DATA_W-1:0] lane_val_r,
  output logic                              lane_sat_r
);

  logic signed [dlf_pkg::PROD_W-1:0] prod;
  logic signed [dlf_pkg::PROD_W-1:0] bias_sh;
  logic signed [dlf_pkg::PROD_W-1:0] term_nxt;
  logic signed [dlf_pkg::PROD_W-1:0] term_r;
  logic        [dlf_pkg::SUM_W-1:0]  sum_nxt;
  logic        [dlf_pkg::SUM_W-1:0]  acc_r;
  logic        [dlf_pkg::SUM_W-1:0]  fin_r;

  logic                              relu_pos;
  logic        [dlf_pkg::SUM_W-1:0]  relu_rnd;
  logic        [dlf_pkg::SUM_W-13:0] relu_q;
  logic                              relu_sat;
  logic        [dlf_pkg::DATA_W-1:0] relu_val;

  logic                              sig_lo;
  logic                              sig_hi;
  logic [dlf_pkg::SIG_SPAN_W-1:0]    sig_span;
  logic [dlf_pkg::SIG_SPAN_W+dlf_pkg::SIG_IDX_W-1:0] sig_prod;
  logic [dlf_pkg::SIG_IDX_W-1:0]     sig_idx;
  logic [dlf_pkg::DATA_W-1:0]        sig_val;

  // product stage: activation times weight, or the negated bias in Q.24
  assign prod     = dlf_pkg::PROD_W'(act_in) * dlf_pkg::PROD_W'(weight_in);
  assign bias_sh  = {{4{weight_in[dlf_pkg::DATA_W-1]}}, weight_in, 12'h000};
  assign term_nxt = ctl.take_bias ? -bias_sh : prod;

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      term_r <= term_nxt;
    end
  end

  // accumulate stage: sums wrap at 40 bits, a bias row closes the sample
  assign sum_nxt = acc_r + dlf_pkg::SUM_W'(term_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.a_vld) begin
      acc_r <= ctl.a_bias ? '0 : sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.a_vld && ctl.a_bias) begin
      fin_r <= sum_nxt;
    end
  end

  // relu: round off 12 fraction bits, clip to the positive 16-bit range
  // a positive sum is below 2^39, so the rounding add cannot wrap
  assign relu_pos = !fin_r[dlf_pkg::SUM_W-1] && (|fin_r[dlf_pkg::SUM_W-2:0]);
  assign relu_rnd = fin_r + dlf_pkg::SUM_W'(2048);
  assign relu_q   = relu_rnd[dlf_pkg::SUM_W-1:12];
  assign relu_sat = relu_pos && (|relu_q[dlf_pkg::SUM_W-13:15]);
  assign relu_val = !relu_pos ? '0 : (relu_sat ? dlf_pkg::RELU_MAX : relu_q[15:0]);

  // sigmoid: clamp to -8..8, offset to unsigned, scale to a table index
  assign sig_lo   = fin_r[dlf_pkg::SUM_W-1] && !(&fin_r[dlf_pkg::SUM_W-2:27]);
  assign sig_hi   = !fin_r[dlf_pkg::SUM_W-1] && (|fin_r[dlf_pkg::SUM_W-2:27]);
  assign sig_span = sig_lo ? '0 : (sig_hi ? '1 : {~fin_r[27], fin_r[26:0]});
  assign sig_prod = (dlf_pkg::SIG_SPAN_W+dlf_pkg::SIG_IDX_W)'(sig_span)
                  * (dlf_pkg::SIG_SPAN_W+dlf_pkg::SIG_IDX_W)'(dlf_pkg::SIG_DEPTH);
  assign sig_idx  = sig_prod[dlf_pkg::SIG_SPAN_W +: dlf_pkg::SIG_IDX_W];
  assign sig_val  = dlf_pkg::SIG_TABLE[sig_idx];

  // activation stage output
  always_ff @(posedge clk) begin
    if (ctl.b_vld) begin
      lane_val_r <= ctl.b_sig ? sig_val : relu_val;
      lane_sat_r <= !ctl.b_sig && relu_sat;
    end
  end

endmodule

>>> hdl/dlf_merge.sv
// dlf_merge: combines lane outputs into one result word and buffers results
// depends on dlf_pkg (word types, buffer sizing)

module dlf_merge (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      push,
  input  logic [dlf_pkg::LANES-1:0][dlf_pkg::DATA_W-1:0] lane_val,
  input  logic [dlf_pkg::LANES-1:0]                 lane_sat,
  input  logic [1:0]                                inflight,
  input  logic                                      out_stall,
  output logic                                      out_valid,
  output dlf_pkg::out_word_t                        out_data,
  output logic                                      res_full
);

  dlf_pkg::out_word_t              word;
  dlf_pkg::out_word_t              mem_r [dlf_pkg::RES_FIFO_DEPTH];
  logic [dlf_pkg::RES_PTR_W-1:0]   wr_ptr_r;
  logic [dlf_pkg::RES_PTR_W-1:0]   rd_ptr_r;
  logic [dlf_pkg::RES_CNT_W-1:0]   cnt_r;
  logic [dlf_pkg::RES_CNT_W-1:0]   cnt_nxt;
  logic [dlf_pkg::RES_CNT_W-1:0]   occ;
  logic                            pop;

  // merge: pack lanes, any clipped lane flags the word
  always_comb begin
    word.neuron_out0 = $signed(lane_val[0]);
    word.neuron_out1 = $signed(lane_val[1]);
    word.neuron_out2 = $signed(lane_val[2]);
    word.neuron_out3 = $signed(lane_val[3]);
    word.saturated   = |lane_sat;
  end

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  // room check covers buffered words plus bias rows still in the lanes
  assign occ      = cnt_r + dlf_pkg::RES_CNT_W'(inflight);
  assign res_full = (occ >= dlf_pkg::RES_CNT_W'(dlf_pkg::RES_FIFO_DEPTH));

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // result buffer pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= word;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != dlf_pkg::RES_CNT_W'(dlf_pkg::RES_FIFO_DEPTH)))
    else $error("result pushed into a full buffer");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= dlf_pkg::RES_CNT_W'(dlf_pkg::RES_FIFO_DEPTH))
    else $error("buffered plus in-flight results exceed buffer depth");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("count did not drop after a pop");

endmodule

>>> hdl/dense_layer_forward.sv
// dense_layer_forward: top level of the four-lane fully connected layer
// depends on dlf_pkg, dlf_lane and dlf_merge

// Takes one input word per clock while in_stall is low, with no bubbles:
// each word's activation is multiplied by each lane's weight and added into
// a 40-bit sum per lane. A bias row subtracts the lane biases, applies ReLU
// (mode 0) or sigmoid (mode 1; always sigmoid for a bias row with no inputs
// before it) and produces one result word. The depth is product, accumulate,
// activate, then an 8-entry result buffer whose head drives the output.
// in_stall rises only when that buffer plus bias rows still in the lanes
// would fill it, i.e. after several results are left waiting at the output.
// Write activation_mode only while idle.

module dense_layer_forward (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dlf_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dlf_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_activation_mode
);

  logic                                    take;
  logic                                    mode_r;
  logic                                    had_input_r;
  logic                                    a_vld_r;
  logic                                    a_bias_r;
  logic                                    b_vld_r;
  logic                                    b_sig_r;
  logic                                    c_vld_r;
  logic [1:0]                              inflight;
  logic                                    res_full;
  dlf_pkg::lane_ctl_t                      ctl;
  logic signed [dlf_pkg::DATA_W-1:0]       lane_w [dlf_pkg::LANES];
  logic [dlf_pkg::LANES-1:0][dlf_pkg::DATA_W-1:0] lane_val;
  logic [dlf_pkg::LANES-1:0]               lane_sat;

  assign take      = in_valid && !in_stall;
  assign in_stall  = res_full;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= dlf_pkg::MODE_RELU;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_activation_mode;
    end
  end

  // control pipeline alongside the lane datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      a_bias_r    <= 1'b0;
      b_vld_r     <= 1'b0;
      b_sig_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      had_input_r <= 1'b0;
    end else begin
      a_vld_r  <= take;
      a_bias_r <= in_data.bias_item;
      b_vld_r  <= a_vld_r && a_bias_r;
      b_sig_r  <= (mode_r == dlf_pkg::MODE_SIGMOID) || !had_input_r;
      c_vld_r  <= b_vld_r;
      if (a_vld_r) begin
        had_input_r <= !a_bias_r;
      end
    end
  end

  assign inflight = 2'(a_vld_r && a_bias_r) + 2'(b_vld_r) + 2'(c_vld_r);

  always_comb begin
    ctl.take      = take;
    ctl.take_bias = in_data.bias_item;
    ctl.a_vld     = a_vld_r;
    ctl.a_bias    = a_bias_r;
    ctl.b_vld     = b_vld_r;
    ctl.b_sig     = b_sig_r;
  end

  // per-lane weights from the input word
  assign lane_w[0] = in_data.weight_lane0;
  assign lane_w[1] = in_data.weight_lane1;
  assign lane_w[2] = in_data.weight_lane2;
  assign lane_w[3] = in_data.weight_lane3;

  // neuron lanes
  for (genvar g = 0; g < dlf_pkg::LANES; g++) begin : g_lane
    dlf_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .act_in     (in_data.activation_in),
      .weight_in  (lane_w[g]),
      .lane_val_r (lane_val[g]),
      .lane_sat_r (lane_sat[g])
    );
  end

  // merge and result buffer
  dlf_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (c_vld_r),
    .lane_val  (lane_val),
    .lane_sat  (lane_sat),
    .inflight  (inflight),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .res_full  (res_full)
  );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for dense_layer_forward (four-lane dense layer, relu/sigmoid)
// depends on dlf_pkg for the word types; predicts results with its own lane model

module tb_top;

  localparam int  HALF_PERIOD  = 10;
  localparam int  RESET_CYCLES = 6;
  localparam int  SETTLE       = 12;    // pipeline depth plus margin
  localparam int  HOLD_CYCLES  = 300;   // long output hold-off
  localparam int  STALL_LIMIT  = 3000;  // cycles without any handshake
  localparam int  PHASES       = 8;
  localparam int  PHASE_WORDS  = 210;
  localparam int  WRAP_WORDS   = 520;   // enough 2^30 products to wrap a 40-bit sum
  localparam int  SHOW_FAILS   = 10;
  localparam longint CLAMP_Q24 = 64'sd1 <<< 27;
  localparam longint ONE_Q30   = 64'sd1 <<< 30;

  typedef struct {
    logic               mode;
    dlf_pkg::in_word_t  w;
    bit                 typed;
    dlf_pkg::out_word_t want;
  } plan_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  dlf_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_stall;
  dlf_pkg::out_word_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_activation_mode;

  // lane model state
  logic [39:0] lane_acc [4];
  bit          saw_input;
  bit          act_sig;
  logic [15:0] sig_lut [256];

  dlf_pkg::out_word_t expected_q [$];
  plan_row_t          plan [$];
  bit          idle_en;
  bit          hold_req;
  int          fail_count;
  int          words_sent;
  int          samples_sent;
  int          results_seen;
  int          sat_seen;
  int          cfg_writes;
  int          quiet_cycles;

  dense_layer_forward uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data             (in_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_data            (out_data),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_activation_mode (cfg_activation_mode)
  );

  // clock
  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  // e^-f for f in [0, 1], both in Q30, alternating series
  function automatic longint exp_q30(input longint f);
    longint acc;
    longint term;
    acc  = ONE_Q30;
    term = ONE_Q30;
    for (int k = 1; k < 24; k++) begin
      term = ((term * f) >>> 30) / k;
      acc  = (k % 2 == 1) ? acc - term : acc + term;
    end
    return acc;
  endfunction

  // sigmoid lookup: value at the center of each bin over -8..8, rounded to Q4.12
  initial begin
    longint e1;
    longint ctr;
    longint mag;
    longint e;
    longint num;
    longint q;
    e1 = exp_q30(ONE_Q30);
    for (int i = 0; i < 256; i++) begin
      ctr = longint'(2 * i + 1) * (CLAMP_Q24 / 256) - CLAMP_Q24;
      mag = (ctr < 0) ? -ctr : ctr;
      e   = exp_q30((mag & ((64'sd1 <<< 24) - 1)) <<< 6);
      for (longint n = 0; n < (mag >>> 24); n++) begin
        e = (e * e1) >>> 30;
      end
      num        = (ctr < 0) ? e : ONE_Q30;
      q          = (num <<< 30) / (ONE_Q30 + e);
      sig_lut[i] = 16'((q * 4096 + (64'sd1 <<< 29)) >>> 30);
    end
  end

  // lane model: accumulate, or on a bias row activate and produce one result word
  function automatic bit layer_step(input dlf_pkg::in_word_t w,
                                    output dlf_pkg::out_word_t r);
    logic signed [15:0] wt [4];
    logic        [15:0] q [4];
    longint             v;
    bit                 use_sig;
    bit                 sat;
    wt  = '{w.weight_lane0, w.weight_lane1, w.weight_lane2, w.weight_lane3};
    r   = '0;
    sat = 1'b0;
    if (!w.bias_item) begin
      for (int k = 0; k < 4; k++) begin
        lane_acc[k] = lane_acc[k] + 40'(longint'($signed(w.activation_in)) *
                                        longint'($signed(wt[k])));
      end
      saw_input = 1'b1;
      return 1'b0;
    end
    // a sample with no inputs always goes through sigmoid
    use_sig = act_sig || !saw_input;
    for (int k = 0; k < 4; k++) begin
      lane_acc[k] = lane_acc[k] - 40'(longint'($signed(wt[k])) * 4096);
      v = longint'($signed(lane_acc[k]));
      if (use_sig) begin
        if (v < -CLAMP_Q24) v = -CLAMP_Q24;
        if (v > CLAMP_Q24 - 1) v = CLAMP_Q24 - 1;
        q[k] = sig_lut[(v + CLAMP_Q24) >>> 20];
      end else if (v <= 0) begin
        q[k] = '0;
      end else begin
        v = (v + 2048) >>> 12;
        if (v > 32767) begin
          v   = 32767;
          sat = 1'b1;
        end
        q[k] = v[15:0];
      end
      lane_acc[k] = '0;
    end
    r.neuron_out0 = q[0];
    r.neuron_out1 = q[1];
    r.neuron_out2 = q[2];
    r.neuron_out3 = q[3];
    r.saturated   = sat;
    saw_input     = 1'b0;
    return 1'b1;
  endfunction

  function automatic dlf_pkg::in_word_t in_w(input logic [15:0] a, w0, w1, w2, w3,
                                             input logic b);
    dlf_pkg::in_word_t w;
    w.activation_in = a;
    w.weight_lane0  = w0;
    w.weight_lane1  = w1;
    w.weight_lane2  = w2;
    w.weight_lane3  = w3;
    w.bias_item     = b;
    return w;
  endfunction

  function automatic dlf_pkg::out_word_t res_w(input logic [15:0] o0, o1, o2, o3,
                                               input logic s);
    dlf_pkg::out_word_t r;
    r.neuron_out0 = o0;
    r.neuron_out1 = o1;
    r.neuron_out2 = o2;
    r.neuron_out3 = o3;
    r.saturated   = s;
    return r;
  endfunction

  // append one directed row to the table
  function automatic void add_row(input logic m, input dlf_pkg::in_word_t w,
                                  input bit typed, input dlf_pkg::out_word_t want);
    plan_row_t row;
    row.mode  = m;
    row.w     = w;
    row.typed = typed;
    row.want  = want;
    plan.insert(plan.size(), row);
  endfunction

  // mostly small values so sums land inside the interesting range
  function automatic logic [15:0] rand_q();
    logic [15:0] edges [5];
    edges = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
    case ($urandom_range(9))
      0, 1:    return 16'($urandom_range(16'hffff));
      2:       return edges[$urandom_range(4)];
      default: return 16'(int'($urandom_range(8192)) - 4096);
    endcase
  endfunction

  // offer one word, wait for the handshake, then predict
  task automatic push(input dlf_pkg::in_word_t w, input bit typed = 1'b0,
                      input dlf_pkg::out_word_t want = '0);
    dlf_pkg::out_word_t r;
    while (idle_en && $urandom_range(99) < 24) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (layer_step(w, r)) begin
      expected_q.insert(expected_q.size(), typed ? want : r);
    end
  endtask

  task automatic send_sample(input int len);
    for (int i = 0; i < len; i++) begin
      push(in_w(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), 1'b0));
    end
    push(in_w(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), 1'b1));
    samples_sent++;
  endtask

  // drain, let the pipeline settle, then write the mode register
  task automatic write_mode(input logic m);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid           <= 1'b1;
    cfg_activation_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    act_sig = m;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic note_fail(input string what, input int e, input int g);
    fail_count++;
    if (fail_count <= SHOW_FAILS) begin
      $display("mismatch at %0t on %s: expected %0d, got %0d", $realtime, what, e, g);
    end
  endtask

  // receiver: random stalls, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= idle_en && ($urandom_range(99) < 24);
      end
    end
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : result_check
    dlf_pkg::out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.saturated) sat_seen++;
      if (expected_q.size() == 0) begin
        note_fail("result word with nothing pending", 0, 1);
      end else begin
        e = expected_q.pop_front();
        if (out_data.neuron_out0 !== e.neuron_out0)
          note_fail("neuron_out0", e.neuron_out0, out_data.neuron_out0);
        if (out_data.neuron_out1 !== e.neuron_out1)
          note_fail("neuron_out1", e.neuron_out1, out_data.neuron_out1);
        if (out_data.neuron_out2 !== e.neuron_out2)
          note_fail("neuron_out2", e.neuron_out2, out_data.neuron_out2);
        if (out_data.neuron_out3 !== e.neuron_out3)
          note_fail("neuron_out3", e.neuron_out3, out_data.neuron_out3);
        if (out_data.saturated !== e.saturated)
          note_fail("saturated", e.saturated, out_data.saturated);
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results pending",
                 STALL_LIMIT, expected_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // directed rows; expected values typed in where they follow directly
  initial begin
    // empty sample in relu mode still goes through sigmoid
    add_row(1'b0, in_w(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1),
            1'b0, '0);
    // 1.0 times 1.0, 2.0, -1.0, 0
    add_row(1'b0, in_w(16'h1000, 16'h1000, 16'h2000, 16'hf000, 16'h0000, 1'b0),
            1'b0, '0);
    add_row(1'b0, in_w(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1),
            1'b1, res_w(16'd4096, 16'd8192, 16'd0, 16'd0, 1'b0));
    // most negative times most negative, then extreme biases: all lanes clip
    add_row(1'b0, in_w(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0),
            1'b0, '0);
    add_row(1'b0, in_w(16'h7fff, 16'h7fff, 16'h8000, 16'h0000, 16'hffff, 1'b1),
            1'b1, res_w(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1));
    // empty sample with a large negative bias: sigmoid top end
    add_row(1'b0, in_w(16'hffff, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1),
            1'b0, '0);
    add_row(1'b0, in_w(16'h7fff, 16'h7fff, 16'h8000, 16'h0000, 16'h0001, 1'b0),
            1'b0, '0);
    add_row(1'b0, in_w(16'hffff, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 1'b0),
            1'b0, '0);
    add_row(1'b0, in_w(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1),
            1'b0, '0);
    // relu rounding at the half-lsb points
    add_row(1'b0, in_w(16'h0001, 16'h0800, 16'h07ff, 16'hf800, 16'h1800, 1'b0),
            1'b0, '0);
    add_row(1'b0, in_w(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1),
            1'b1, res_w(16'd1, 16'd0, 16'd0, 16'd2, 1'b0));
    // sigmoid mode: empty sample, clamp at both ends, no saturation flag
    add_row(1'b1, in_w(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1),
            1'b0, '0);
    add_row(1'b1, in_w(16'h8000, 16'h8000, 16'h7fff, 16'h0000, 16'h0001, 1'b0),
            1'b0, '0);
    add_row(1'b1, in_w(16'h1234, 16'h0000, 16'h0000, 16'h8000, 16'h7fff, 1'b1),
            1'b0, '0);
    add_row(1'b1, in_w(16'h1000, 16'h0800, 16'hf800, 16'h0100, 16'hff00, 1'b0),
            1'b0, '0);
    add_row(1'b1, in_w(16'h0000, 16'h0400, 16'h0000, 16'hfc00, 16'h0001, 1'b1),
            1'b0, '0);
    // a zero input word still makes the sample non-empty
    add_row(1'b0, in_w(16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 1'b0),
            1'b0, '0);
    add_row(1'b0, in_w(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1),
            1'b1, res_w(16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
  end

  // stimulus
  initial begin
    int start_words;
    int len;
    int r;
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_data             = '0;
    cfg_valid           = 1'b0;
    cfg_activation_mode = 1'b0;
    idle_en             = 1'b1;
    hold_req            = 1'b0;
    act_sig             = 1'b0;
    saw_input           = 1'b0;
    for (int k = 0; k < 4; k++) lane_acc[k] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    write_mode(1'b0);
    foreach (plan[i]) begin
      if (plan[i].mode != act_sig) write_mode(plan[i].mode);
      push(plan[i].w, plan[i].typed, plan[i].want);
    end

    // random phases, alternating the mode
    for (int p = 0; p < PHASES; p++) begin
      write_mode(1'(p % 2));
      idle_en     = (p != 3);
      start_words = words_sent;
      if (p == 1) begin
        // enough extreme products to wrap every lane sum
        for (int i = 0; i < WRAP_WORDS; i++) begin
          push(in_w(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0));
        end
        push(in_w(rand_q(), 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
        samples_sent++;
      end
      if (p == 5) begin
        // hold the output while short samples keep coming, so the buffer fills
        hold_req = 1'b1;
        repeat (30) send_sample(1);
      end
      while (words_sent - start_words < PHASE_WORDS) begin
        r = $urandom_range(99);
        if (r < 5) len = 0;
        else if (r < 85) len = $urandom_range(8, 1);
        else if (r < 97) len = $urandom_range(40, 9);
        else len = $urandom_range(80, 41);
        send_sample(len);
      end
    end

    // drain and finish
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d input words in %0d samples, %0d result words (%0d saturated)",
             words_sent, samples_sent, results_seen, sat_seen);
    $display("mode register written %0d times, with random stalls and a %0d-cycle output hold",
             cfg_writes, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches in total", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
